### sv/aou_pkg.sv
`default_nettype none
package aou_pkg;

  localparam int ENTRIES   = 4096;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int V_W       = 48;
  localparam int POW_W     = 33;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int DELTA_W   = 41;
  localparam int DVD_W     = 96;
  localparam int DIV_W     = 50;
  localparam int REM_W     = 51;
  localparam int ROOT_W    = 48;
  localparam int CNT_W     = 7;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  localparam logic [DATA_W-1:0] LR_RESET  = 32'd4294967;
  localparam logic [DATA_W-1:0] WD_RESET  = 32'd0;
  localparam logic [DATA_W-1:0] B1_RESET  = 32'd3865470566;
  localparam logic [DATA_W-1:0] B2_RESET  = 32'd4290672329;
  localparam logic [DATA_W-1:0] EPS_RESET = 32'd43;

  localparam logic [POW_W-1:0]   ONE_Q32     = 33'h1_0000_0000;
  localparam logic [DELTA_W-1:0] DELTA_LIMIT = 41'h100_0000_0000;
  localparam logic [DATA_W-1:0]  STEP_MAX    = 32'hFFFF_FFFF;

  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_UPDATE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SAT    = 2'd1,
    STATUS_NOSTEP = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LR  = 3'd0,
    REG_WD  = 3'd1,
    REG_B1  = 3'd2,
    REG_B2  = 3'd3,
    REG_EPS = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECAY, S_M1, S_M2, S_M3, S_DIVM, S_SETV, S_DIVV,
    S_SETS, S_SQRT, S_SETQ, S_PROD, S_PROD2, S_DIVQ, S_OUT
  } back_state_t;

  typedef struct packed {
    kind_t                     kind;
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  param;
    logic signed [DATA_W-1:0]  grad;
  } q_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } front_ctl_t;

endpackage
`default_nettype wire

### sv/aou_front.sv
`default_nettype none
module aou_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [aou_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [0:0]                      s_axis_tuser,
  input  wire aou_pkg::front_ctl_t             ctl,
  output logic                                 item_valid,
  output aou_pkg::q_item_t                     item
);
  import aou_pkg::*;

  q_item_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  q_item_t            in_item;
  logic               push;

  // Classify the transaction: tuser says whether it advances the step or updates an element.
  always_comb begin
    in_item.kind  = s_axis_tuser[0] ? KIND_UPDATE : KIND_ADVANCE;
    in_item.idx   = s_axis_tdata[11:0];
    in_item.param = $signed(s_axis_tdata[43:12]);
    in_item.grad  = $signed(s_axis_tdata[75:44]);
  end

  assign s_axis_tready = (count != (QPTR_W+1)'(QDEPTH)) && !ctl.clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (count != '0);
  assign item          = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, ctl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/aou_back.sv
`default_nettype none
module aou_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [aou_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [aou_pkg::DATA_W-1:0]       cfg_data,
  input  wire logic                             item_valid,
  input  wire aou_pkg::q_item_t                 item,
  output aou_pkg::front_ctl_t                   ctl,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [aou_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic [1:0]                            m_axis_tuser
);
  import aou_pkg::*;

  // Configuration and optimiser step state.
  logic [DATA_W-1:0] lr, wd, b1, b2, eps;
  logic [DATA_W-1:0] step;
  logic [POW_W-1:0]  p1, p2;

  back_state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr;

  // Moment stores.
  logic signed [DATA_W-1:0] m_mem [ENTRIES];
  logic [V_W-1:0]           v_mem [ENTRIES];
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_wa, mem_ra;
  logic signed [DATA_W-1:0] mem_wm, m_rd;
  logic [V_W-1:0]           mem_wv, v_rd;

  // Item being worked on.
  logic [IDX_W-1:0]         it_idx;
  logic signed [DATA_W-1:0] it_param, it_grad;
  logic signed [DATA_W-1:0] g, mnew;
  logic                     sat;
  logic signed [64:0]       mt1;
  logic [V_W-1:0]           gsq, vph, vnew;
  logic [DATA_W-1:0]        vpl;
  logic [48:0]              vs1, gqh;
  logic [POW_W-1:0]         gql;
  logic [63:0]              mh, vhat, plo;
  logic [DELTA_W-1:0]       delta;

  // Shared shift-subtract unit for division and square root.
  logic [DVD_W-1:0]  dvd;
  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [63:0]       quo;
  logic              qbig;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;

  logic              out_valid;
  logic [IDX_W-1:0]  out_idx;
  logic [DATA_W-1:0] out_param;
  status_t           out_status;

  logic out_free, pop, out_load;

  // Combinational datapath terms.
  logic signed [64:0] wd_prod;
  logic signed [34:0] g_sum;
  logic [32:0]        gneg;
  logic [DATA_W-1:0]  gmag;
  logic [63:0]        gsq_full, vpl_full;
  logic [POW_W-1:0]   c1, c2, bc1, bc2;
  logic signed [65:0] m_t;
  logic signed [66:0] m_sum;
  logic [64:0]        gql_full, p1_mul, p2_mul;
  logic [49:0]        vnew_w;
  logic [32:0]        mneg;
  logic [DATA_W-1:0]  mmag;
  logic [REM_W:0]     d_sh, d_sub;
  logic               d_ge;
  logic [63:0]        quo_next;
  logic               qbig_next;
  logic [REM_W+1:0]   s_sh, s_trial, s_sub;
  logic               s_ge;
  logic [DIV_W-1:0]   dsum;
  logic [63:0]        phi;
  logic [DVD_W-1:0]   prod96;
  logic signed [42:0] res;

  function automatic logic signed [42:0] it_item_sign(
    input logic neg, input logic signed [DATA_W-1:0] prm, input logic [DELTA_W-1:0] dl);
    logic signed [42:0] dv;
    dv = $signed({2'b00, dl});
    return neg ? 43'(prm) + dv : 43'(prm) - dv;
  endfunction

  always_comb begin
    wd_prod  = 65'($signed({1'b0, wd})) * 65'(it_param);
    g_sum    = 35'(it_grad) + 35'($signed(wd_prod[64:32]));
    gneg     = -$signed({g[DATA_W-1], g});
    gmag     = g[DATA_W-1] ? gneg[31:0] : g;
    gsq_full = 64'(gmag) * 64'(gmag);
    vpl_full = 64'(v_rd[31:0]) * 64'(b2);
    c1       = ONE_Q32 - {1'b0, b1};
    c2       = ONE_Q32 - {1'b0, b2};
    m_t      = 66'($signed({1'b0, c1})) * 66'(g);
    m_sum    = 67'(mt1) + 67'(m_t);
    gql_full = 65'(gsq[31:0]) * 65'(c2);
    vnew_w   = 50'(vs1) + 50'(gqh) + 50'(gql);
    mneg     = -$signed({mnew[DATA_W-1], mnew});
    mmag     = mnew[DATA_W-1] ? mneg[31:0] : mnew;
    bc1      = (p1 == ONE_Q32) ? POW_W'(1) : ONE_Q32 - p1;
    bc2      = (p2 == ONE_Q32) ? POW_W'(1) : ONE_Q32 - p2;
    p1_mul   = 65'(p1) * 65'(b1);
    p2_mul   = 65'(p2) * 65'(b2);
    // One restoring division step.
    d_sh      = {rem, dvd[DVD_W-1]};
    d_ge      = d_sh >= (REM_W+1)'(dvs);
    d_sub     = d_sh - (REM_W+1)'(dvs);
    quo_next  = {quo[62:0], d_ge};
    qbig_next = qbig | quo[63];
    // One square root digit.
    s_sh    = {rem, dvd[DVD_W-1:DVD_W-2]};
    s_trial = (REM_W+2)'({root, 2'b01});
    s_ge    = s_sh >= s_trial;
    s_sub   = s_sh - s_trial;
    dsum    = DIV_W'(root) + DIV_W'(eps);
    phi     = 64'(mh[63:32]) * 64'(lr);
    prod96  = DVD_W'(plo) + {phi, 32'b0};
    res     = it_item_sign(mnew[DATA_W-1], it_param, delta);
  end

  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = clr_addr;
    mem_ra     = item.idx[ADDR_W-1:0];
    mem_wm     = '0;
    mem_wv     = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == ADDR_W'(ENTRIES-1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid && (item.kind == KIND_ADVANCE || out_free)) begin
          pop = 1'b1;
          if (item.kind == KIND_UPDATE) begin
            if (step == '0) begin
              out_load = 1'b1;
            end else begin
              mem_re     = 1'b1;
              state_next = S_DECAY;
            end
          end
        end
      end
      S_DECAY: state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3: begin
        mem_we     = 1'b1;
        mem_wa     = it_idx[ADDR_W-1:0];
        mem_wm     = mnew;
        mem_wv     = vnew_w[V_W-1:0];
        state_next = S_DIVM;
      end
      S_DIVM:  if (cnt == CNT_W'(1)) state_next = S_SETV;
      S_SETV: begin
        if (POW_W'(vnew[47:32]) >= bc2) begin
          state_next = S_SETS;
        end else begin
          state_next = S_DIVV;
        end
      end
      S_DIVV:  if (cnt == CNT_W'(1)) state_next = S_SETS;
      S_SETS:  state_next = S_SQRT;
      S_SQRT:  if (cnt == CNT_W'(1)) state_next = S_SETQ;
      S_SETQ: begin
        if (mh == '0 || dsum == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PROD;
        end
      end
      S_PROD:  state_next = S_PROD2;
      S_PROD2: state_next = S_DIVQ;
      S_DIVQ:  if (cnt == CNT_W'(1)) state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m_mem[mem_wa] <= mem_wm;
      v_mem[mem_wa] <= mem_wv;
    end
    if (mem_re) begin
      m_rd <= m_mem[mem_ra];
      v_rd <= v_mem[mem_ra];
    end
  end

  // Control state: configuration, step count, powers, clearing sweep, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      lr        <= LR_RESET;
      wd        <= WD_RESET;
      b1        <= B1_RESET;
      b2        <= B2_RESET;
      eps       <= EPS_RESET;
      step      <= '0;
      p1        <= ONE_Q32;
      p2        <= ONE_Q32;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LR:  lr  <= cfg_data;
          REG_WD:  wd  <= cfg_data;
          REG_B1:  b1  <= cfg_data;
          REG_B2:  b2  <= cfg_data;
          REG_EPS: eps <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop && item.kind == KIND_ADVANCE) begin
        if (step != STEP_MAX) begin
          step <= step + 1'b1;
        end
        p1 <= p1_mul[64:32];
        p2 <= p2_mul[64:32];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        it_idx   <= item.idx;
        it_param <= item.param;
        it_grad  <= item.grad;
        sat      <= 1'b0;
        delta    <= '0;
      end
      S_DECAY: begin
        if (g_sum > 35'sd2147483647) begin
          g   <= 32'sh7FFF_FFFF;
          sat <= 1'b1;
        end else if (g_sum < -35'sd2147483648) begin
          g   <= 32'sh8000_0000;
          sat <= 1'b1;
        end else begin
          g <= g_sum[31:0];
        end
      end
      S_M1: begin
        mt1 <= 65'($signed({1'b0, b1})) * 65'(m_rd);
        gsq <= gsq_full[63:16];
        vph <= V_W'(v_rd[47:32]) * V_W'(b2);
        vpl <= vpl_full[63:32];
      end
      S_M2: begin
        mnew <= m_sum[63:32];
        vs1  <= 49'(vph) + 49'(vpl);
        gqh  <= 49'(gsq[47:32]) * 49'(c2);
        gql  <= gql_full[64:32];
      end
      S_M3: begin
        vnew <= vnew_w[V_W-1:0];
        dvd  <= {mmag, 64'b0};
        dvs  <= DIV_W'(bc1);
        rem  <= '0;
        quo  <= '0;
        qbig <= 1'b0;
        cnt  <= CNT_W'(64);
      end
      S_DIVM, S_DIVV, S_DIVQ: begin
        rem  <= d_ge ? d_sub[REM_W-1:0] : d_sh[REM_W-1:0];
        quo  <= quo_next;
        qbig <= qbig_next;
        dvd  <= {dvd[DVD_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          if (state == S_DIVM) begin
            mh <= quo_next;
          end else if (state == S_DIVV) begin
            vhat <= quo_next;
          end else if (qbig_next || quo_next >= 64'(DELTA_LIMIT)) begin
            delta <= DELTA_LIMIT;
            sat   <= 1'b1;
          end else begin
            delta <= quo_next[DELTA_W-1:0];
          end
        end
      end
      S_SETV: begin
        vhat <= '1;
        dvd  <= {vnew, 48'b0};
        dvs  <= DIV_W'(bc2);
        rem  <= '0;
        quo  <= '0;
        qbig <= 1'b0;
        cnt  <= CNT_W'(80);
      end
      S_SETS: begin
        dvd  <= {vhat, 32'b0};
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(ROOT_W);
      end
      S_SQRT: begin
        rem  <= s_ge ? s_sub[REM_W-1:0] : s_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], s_ge};
        dvd  <= {dvd[DVD_W-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
      end
      S_SETQ: begin
        dvs <= dsum;
        // A zero denominator with a non-zero first moment forces the limit.
        if (mh != '0 && dsum == '0) begin
          delta <= DELTA_LIMIT;
          sat   <= 1'b1;
        end
      end
      S_PROD: plo <= 64'(mh[31:0]) * 64'(lr);
      S_PROD2: begin
        dvd  <= prod96;
        rem  <= '0;
        quo  <= '0;
        qbig <= 1'b0;
        cnt  <= CNT_W'(DVD_W);
      end
      default: ;
    endcase
    if (out_load) begin
      if (state == S_IDLE) begin
        out_idx    <= item.idx;
        out_param  <= item.param;
        out_status <= STATUS_NOSTEP;
      end else begin
        out_idx <= it_idx;
        if (res > 43'sd2147483647) begin
          out_param  <= 32'h7FFF_FFFF;
          out_status <= STATUS_SAT;
        end else if (res < -43'sd2147483648) begin
          out_param  <= 32'h8000_0000;
          out_status <= STATUS_SAT;
        end else begin
          out_param  <= res[31:0];
          out_status <= sat ? STATUS_SAT : STATUS_OK;
        end
      end
    end
  end

  assign ctl.pop       = pop;
  assign ctl.clearing  = (state == S_CLEAR);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_param, out_idx};
  assign m_axis_tuser  = out_status;

endmodule
`default_nettype wire

### sv/adam_optimizer_update.sv
`default_nettype none
// Channel   Direction  Handshake                  Contents
// s_axis    in         tvalid/tready              tdata: index, param, gradient; tuser: mode
// m_axis    out        tvalid/tready              tdata: index, new param; tuser: status
// cfg       in         cfg_we, no wait            cfg_index, cfg_data (32-bit registers)
//
// An advance transaction and an update before the first advance are handled in the back
// end's idle state. A full update runs through the shared shift-subtract unit: 64 + 80
// division steps, 48 root digits and 96 quotient steps; the 80 and 96 may each be skipped.
// After reset the moment stores are swept to zero with s_axis_tready low.
// A four-entry queue parts the front from the back; a held result stalls only the back.
module adam_optimizer_update (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // element_index[11:0], param_value[43:12], gradient[75:44], zero fill
  input  wire logic [aou_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode[0]
  input  wire logic [0:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // element_index_out[11:0], updated_param[43:12], zero fill
  output logic [aou_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]                            m_axis_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [aou_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [aou_pkg::DATA_W-1:0]       cfg_data
);
  import aou_pkg::*;

  front_ctl_t ctl;
  logic       item_valid;
  q_item_t    item;

  aou_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .ctl           (ctl),
    .item_valid    (item_valid),
    .item          (item)
  );

  aou_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item          (item),
    .ctl           (ctl),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    ctl.clearing |-> !s_axis_tready)
    else $error("input accepted during the clearing sweep");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> item_valid)
    else $error("queue popped while empty");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_SAT ||
                       m_axis_tuser == STATUS_NOSTEP))
    else $error("undefined result status");

endmodule
`default_nettype wire
